>>> sv/lsc_pkg.sv
// lsc_pkg: shared codes, field widths and types for the LRU stamp cache tag store.
// No dependencies; used by lsc_scan_unit and lru_stamp_cache_tag_store_unit.

package lsc_pkg;

    // Fixed field widths of the stream payloads
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;

    // Request kinds (slave tuser)
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INVAL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    // Result status codes (master tuser)
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVAL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FLUSH  = 3'd4;

    // Sequencer to compare unit: one tag word is on the RAM read port
    typedef struct packed {
        logic dv;     // read data is valid this cycle
        logic first;  // read data belongs to entry 0 (restarts the oldest search)
    } t_scan_ctl;

endpackage

>>> sv/lsc_ram.sv
// lsc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module lsc_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/lsc_scan_unit.sv
// lsc_scan_unit: shared key compare and oldest-stamp tracker, one tag word per cycle.
// Depends on lsc_pkg (t_scan_ctl).

module lsc_scan_unit #(
    parameter int KEY_BITS   = 16,
    parameter int STAMP_BITS = 32,
    parameter int IDX_W      = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsc_pkg::t_scan_ctl    i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic                  i_ent_valid,
    input  logic [KEY_BITS-1:0]   i_ent_key,
    input  logic [STAMP_BITS-1:0] i_ent_stamp,
    input  logic [KEY_BITS-1:0]   i_key,
    output logic                  o_match,
    output logic [IDX_W-1:0]      o_victim
);

    logic [STAMP_BITS-1:0] r_oldest;
    logic [STAMP_BITS-1:0] n_oldest;
    logic [IDX_W-1:0]      r_victim;
    logic [IDX_W-1:0]      n_victim;
    logic                  older;

    assign o_match = i_ent_valid && (i_ent_key == i_key);
    assign older   = i_ent_stamp < r_oldest;

    // First entry with the strictly smallest stamp wins
    always_comb begin
        n_oldest = r_oldest;
        n_victim = r_victim;
        if (i_ctl.first || older) begin
            n_oldest = i_ent_stamp;
            n_victim = i_idx;
        end
    end

    assign o_victim = n_victim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_victim <= '0;
        end else if (i_ctl.dv) begin
            r_victim <= n_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dv) begin
            r_oldest <= n_oldest;
        end
    end

endmodule

>>> sv/lru_stamp_cache_tag_store_unit.sv
// lru_stamp_cache_tag_store_unit: top level of the fully associative LRU tag store.
// Depends on lsc_pkg, lsc_ram and lsc_scan_unit.
//
// Fully associative tag store of ENTRIES entries with least-recently-used
// replacement by use stamps. Each slave transaction carries a request kind in
// tuser (lookup, invalidate, flush) and a key in tdata; each one yields exactly
// one master transaction with a status in tuser and a slot index in tdata.
// A lookup advances the STAMP_BITS use counter (wraps), restamps a hit entry,
// or on a miss takes the first entry with the smallest stamp as victim and
// writes the key and new stamp into it. Invalidate clears the first valid
// matching entry and zeroes its stamp. Flush empties the table and zeroes the
// counter. Valid bit, key and stamp of every entry live in one RAM whose
// single read port is scanned one entry per cycle by a lookup or an
// invalidate, which stops early at the first matching entry. Flush runs a
// clearing pass that writes one entry per cycle. The same clearing pass
// runs after reset, during which s_tready stays low. The unit handles one
// transaction at a time; a finished result is held in an output register, so
// the next request is taken while the previous result waits on m_tready.

module lru_stamp_cache_tag_store_unit #(
    parameter int ENTRIES    = 128,
    parameter int KEY_BITS   = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [((KEY_BITS+7)/8)*8-1:0] i_s_tdata,  // [KEY_BITS-1:0] key
    input  logic [lsc_pkg::REQ_W-1:0]    i_s_tuser,  // [1:0] req_type
    // Result stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [7:0]                   o_m_tdata,  // [6:0] slot
    output logic [lsc_pkg::STATUS_W-1:0] o_m_tuser   // [2:0] status
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = 1 + KEY_BITS + STAMP_BITS;
    localparam int EXT_W  = (IDX_W > lsc_pkg::SLOT_W) ? IDX_W : lsc_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;  // clearing pass, one entry per cycle
    localparam logic [1:0] S_IDLE  = 2'd1;  // ready for a request
    localparam logic [1:0] S_SCAN  = 2'd2;  // scanning the tag RAM
    localparam logic [1:0] S_DONE  = 2'd3;  // result waits for the output register

    logic [1:0]                   r_state;
    logic [IDX_W-1:0]             r_idx;        // read / clear address
    logic                         r_issue_done; // all entries read
    logic                         r_dv;         // read data valid
    logic [IDX_W-1:0]             r_didx;       // entry of the read data
    logic [lsc_pkg::REQ_W-1:0]    r_req;
    logic [KEY_BITS-1:0]          r_key;
    logic [STAMP_BITS-1:0]        r_use_cnt;
    logic                         r_flush;      // clearing pass answers a flush
    logic [lsc_pkg::STATUS_W-1:0] r_res_status;
    logic [IDX_W-1:0]             r_res_slot;
    logic                         r_out_valid;
    logic [lsc_pkg::STATUS_W-1:0] r_out_status;
    logic [IDX_W-1:0]             r_out_slot;

    // RAM ports
    logic                 rd_en;
    logic [WORD_W-1:0]    rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_data;

    // Compare unit
    lsc_pkg::t_scan_ctl   scan_ctl;
    logic                 match;
    logic [IDX_W-1:0]     victim;
    logic                 is_lookup;
    logic                 hit_evt;
    logic                 end_evt;
    logic [EXT_W-1:0]     slot_ext;

    assign is_lookup = (r_req == lsc_pkg::REQ_LOOKUP);

    // Tag word: {valid, key, stamp}; invalid entries always hold a zero stamp
    lsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign scan_ctl.dv    = r_dv && (r_state == S_SCAN);
    assign scan_ctl.first = (r_didx == '0);

    lsc_scan_unit #(
        .KEY_BITS   (KEY_BITS),
        .STAMP_BITS (STAMP_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_idx       (r_didx),
        .i_ent_valid (rd_data[WORD_W-1]),
        .i_ent_key   (rd_data[WORD_W-2 -: KEY_BITS]),
        .i_ent_stamp (rd_data[STAMP_BITS-1:0]),
        .i_key       (r_key),
        .o_match     (match),
        .o_victim    (victim)
    );

    assign rd_en   = (r_state == S_SCAN) && !r_issue_done;
    assign hit_evt = scan_ctl.dv && match;
    assign end_evt = scan_ctl.dv && !match && (r_didx == LAST_IDX);

    // Write port: clearing pass, restamp / invalidate on a hit, victim fill on a miss
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_didx;
        wr_data = '0;
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
        end else if (hit_evt) begin
            wr_en   = 1'b1;
            wr_data = is_lookup ? {1'b1, r_key, r_use_cnt}
                                : {1'b0, r_key, {STAMP_BITS{1'b0}}};
        end else if (end_evt && is_lookup) begin
            wr_en   = 1'b1;
            wr_addr = victim;
            wr_data = {1'b1, r_key, r_use_cnt};
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_dv         <= 1'b0;
            r_flush      <= 1'b0;
            r_use_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // load a finished result, or drain the one taken by the sink
            if ((r_state == S_DONE) && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_req        <= i_s_tuser;
                        r_key        <= i_s_tdata[KEY_BITS-1:0];
                        r_idx        <= '0;
                        r_issue_done <= 1'b0;
                        r_dv         <= 1'b0;
                        case (i_s_tuser)
                            lsc_pkg::REQ_LOOKUP: begin
                                r_use_cnt <= r_use_cnt + 1'b1;
                                r_state   <= S_SCAN;
                            end
                            lsc_pkg::REQ_INVAL: begin
                                r_state <= S_SCAN;
                            end
                            lsc_pkg::REQ_FLUSH: begin
                                r_use_cnt <= '0;
                                r_flush   <= 1'b1;
                                r_state   <= S_CLEAR;
                            end
                            default: begin
                                // unused request kind: no change, answer not present
                                r_res_status <= lsc_pkg::ST_ABSENT;
                                r_res_slot   <= '0;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // r_dv left over here is masked by the state and cleared on accept
                    r_dv   <= rd_en;
                    r_didx <= r_idx;
                    if (rd_en) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (hit_evt) begin
                        r_res_status <= is_lookup ? lsc_pkg::ST_HIT : lsc_pkg::ST_INVAL;
                        r_res_slot   <= r_didx;
                        r_state      <= S_DONE;
                    end else if (end_evt) begin
                        r_res_status <= is_lookup ? lsc_pkg::ST_MISS : lsc_pkg::ST_ABSENT;
                        r_res_slot   <= is_lookup ? victim : '0;
                        r_state      <= S_DONE;
                    end
                end
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_res_status <= lsc_pkg::ST_FLUSH;
                        r_res_slot   <= '0;
                        r_flush      <= 1'b0;
                        // the pass after reset produces no result
                        r_state      <= r_flush ? S_DONE : S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_m_tready)) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    assign slot_ext   = EXT_W'(r_out_slot);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {1'b0, slot_ext[lsc_pkg::SLOT_W-1:0]};

endmodule
